[src/tqc_pkg.sv]
// ----------------------------------------------------------------------------
// tqc_pkg
// Shared types, codes and helper functions of the textured quad clipper.
// ----------------------------------------------------------------------------
package tqc_pkg;

  localparam int PosW       = 20;
  localparam int SizeW      = 19;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 20;
  localparam int QueueDepth = 2;

  typedef logic signed [PosW-1:0] pos_t;
  typedef logic [SizeW-1:0]       size_t;

  typedef enum logic [1:0] {
    ST_REJECT = 2'd0,
    ST_CLIP   = 2'd1,
    ST_PASS   = 2'd2
  } status_t;

  localparam logic [CfgIdxW-1:0] CFG_CLIP_LEFT   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CLIP_TOP    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CLIP_WIDTH  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_CLIP_HEIGHT = 2'd3;

  typedef struct packed {
    pos_t  left;
    pos_t  top;
    size_t width;
    size_t height;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    status_t status;
    pos_t    qx;
    pos_t    qy;
    size_t   qw;
    size_t   qh;
    pos_t    tx;
    pos_t    ty;
    size_t   tw;
    size_t   th;
    pos_t    lx;
    pos_t    ly;
    size_t   sx;
    size_t   sy;
    size_t   ox;
    size_t   oy;
  } item_t;

  typedef struct packed {
    pos_t  lo;
    size_t sz;
    size_t off;
  } axis_t;

  // partial remainder and quotient shift register of one restoring divider
  typedef struct packed {
    size_t rem;
    size_t quo;
  } div_t;

  typedef struct packed {
    status_t status;
    pos_t    x;
    pos_t    y;
    size_t   w;
    size_t   h;
    pos_t    tex_x;
    pos_t    tex_y;
    size_t   tex_w;
    size_t   tex_h;
  } result_t;

  function automatic axis_t clamp_axis(pos_t q, size_t qs, pos_t c, size_t cs);
    logic signed [PosW:0] qv;
    logic signed [PosW:0] cv;
    logic signed [PosW:0] qe;
    logic signed [PosW:0] ce;
    logic signed [PosW:0] lo;
    logic signed [PosW:0] hi;
    logic signed [PosW:0] d;
    logic signed [PosW:0] o;
    axis_t r;
    qv = {q[PosW-1], q};
    cv = {c[PosW-1], c};
    qe = qv + $signed({2'b00, qs});
    ce = cv + $signed({2'b00, cs});
    lo = (qv > cv) ? qv : cv;
    hi = (qe < ce) ? qe : ce;
    d  = hi - lo;
    o  = lo - qv;
    if (lo < hi) begin
      r.lo  = lo[PosW-1:0];
      r.sz  = d[SizeW-1:0];
      r.off = o[SizeW-1:0];
    end else begin
      r.lo  = q;
      r.sz  = '0;
      r.off = '0;
    end
    return r;
  endfunction

  function automatic div_t div_step(div_t d, size_t dv);
    logic [SizeW:0] t;
    logic [SizeW:0] s;
    div_t r;
    t = {d.rem, d.quo[SizeW-1]};
    s = t - {1'b0, dv};
    if (t >= {1'b0, dv}) begin
      r.rem = s[SizeW-1:0];
      r.quo = {d.quo[SizeW-2:0], 1'b1};
    end else begin
      r.rem = t[SizeW-1:0];
      r.quo = {d.quo[SizeW-2:0], 1'b0};
    end
    return r;
  endfunction

  // texture origin plus non-negative offset, saturated at the top
  function automatic pos_t add_sat(pos_t t, size_t q);
    logic [PosW:0] s;
    s = {t[PosW-1], t} + {2'b00, q};
    if (s[PosW] != s[PosW-1]) begin
      return {1'b0, {(PosW-1){1'b1}}};
    end
    return s[PosW-1:0];
  endfunction

endpackage

[src/tqc_in_if.sv]
// ----------------------------------------------------------------------------
// tqc_in_if
// Quad input channel: valid/ready handshake with the quad and texture fields.
// ----------------------------------------------------------------------------
interface tqc_in_if;
  logic              valid;
  logic              ready;
  logic signed [19:0] quad_x;
  logic signed [19:0] quad_y;
  logic [18:0]       quad_w;
  logic [18:0]       quad_h;
  logic signed [19:0] tex_x;
  logic signed [19:0] tex_y;
  logic [18:0]       tex_w;
  logic [18:0]       tex_h;

  modport source (output valid, quad_x, quad_y, quad_w, quad_h,
                  tex_x, tex_y, tex_w, tex_h, input ready);
  modport sink   (input valid, quad_x, quad_y, quad_w, quad_h,
                  tex_x, tex_y, tex_w, tex_h, output ready);
endinterface

[src/tqc_out_if.sv]
// ----------------------------------------------------------------------------
// tqc_out_if
// Result channel: valid/ready handshake with the clipped quad fields.
// ----------------------------------------------------------------------------
interface tqc_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        clip_status;
  logic signed [19:0] out_x;
  logic signed [19:0] out_y;
  logic [18:0]       out_w;
  logic [18:0]       out_h;
  logic signed [19:0] out_tex_x;
  logic signed [19:0] out_tex_y;
  logic [18:0]       out_tex_w;
  logic [18:0]       out_tex_h;

  modport source (output valid, clip_status, out_x, out_y, out_w, out_h,
                  out_tex_x, out_tex_y, out_tex_w, out_tex_h, input ready);
  modport sink   (input valid, clip_status, out_x, out_y, out_w, out_h,
                  out_tex_x, out_tex_y, out_tex_w, out_tex_h, output ready);
endinterface

[src/tqc_front.sv]
// ----------------------------------------------------------------------------
// tqc_front
// Accepts quads, clamps both axes against the clip box and classifies them.
// ----------------------------------------------------------------------------
module tqc_front (
  input  logic           clk,
  input  logic           rst_n,
  input  tqc_pkg::cfg_t  cfg,
  tqc_in_if.sink         in_ch,
  output logic           f_valid,
  output tqc_pkg::item_t f_item,
  input  logic           f_ready
);
  import tqc_pkg::*;

  logic  valid_r;
  item_t item_r;
  item_t item_nxt;
  axis_t ax;
  axis_t ay;

  assign in_ch.ready = !valid_r || f_ready;

  always_comb begin
    ax = clamp_axis(in_ch.quad_x, in_ch.quad_w, cfg.left, cfg.width);
    ay = clamp_axis(in_ch.quad_y, in_ch.quad_h, cfg.top, cfg.height);
    item_nxt.qx = in_ch.quad_x;
    item_nxt.qy = in_ch.quad_y;
    item_nxt.qw = in_ch.quad_w;
    item_nxt.qh = in_ch.quad_h;
    item_nxt.tx = in_ch.tex_x;
    item_nxt.ty = in_ch.tex_y;
    item_nxt.tw = in_ch.tex_w;
    item_nxt.th = in_ch.tex_h;
    item_nxt.lx = ax.lo;
    item_nxt.ly = ay.lo;
    item_nxt.sx = ax.sz;
    item_nxt.sy = ay.sz;
    item_nxt.ox = ax.off;
    item_nxt.oy = ay.off;
    if (ax.sz == in_ch.quad_w && ay.sz == in_ch.quad_h) begin
      item_nxt.status = ST_PASS;
    end else if (ax.sz == '0 || ay.sz == '0) begin
      item_nxt.status = ST_REJECT;
    end else begin
      item_nxt.status = ST_CLIP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      item_r <= item_nxt;
    end
  end

  assign f_valid = valid_r;
  assign f_item  = item_r;
endmodule

[src/tqc_queue.sv]
// ----------------------------------------------------------------------------
// tqc_queue
// Short FIFO between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module tqc_queue #(
  parameter int Depth = tqc_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  tqc_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output tqc_pkg::item_t pop_item
);
  import tqc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  item_t           mem_r [Depth];
  logic [PtrW-1:0] wr_r;
  logic [PtrW-1:0] rd_r;
  logic [CntW-1:0] cnt_r;
  logic            push;
  logic            pop;

  assign push_ready = cnt_r != CntW'(Depth);
  assign pop_valid  = cnt_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == LastPtr) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == LastPtr) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end
endmodule

[src/tqc_back.sv]
// ----------------------------------------------------------------------------
// tqc_back
// Texture rescale: product stage, pipelined restoring dividers, output stage.
// ----------------------------------------------------------------------------
module tqc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           b_valid,
  output logic           b_ready,
  input  tqc_pkg::item_t b_item,
  tqc_out_if.source      out_ch
);
  import tqc_pkg::*;

  localparam int Steps = SizeW;

  logic    adv;
  logic    v_r   [Steps+1];
  item_t   it_r  [Steps+1];
  div_t    dox_r [Steps+1];
  div_t    doy_r [Steps+1];
  div_t    dsx_r [Steps+1];
  div_t    dsy_r [Steps+1];
  logic [2*SizeW-1:0] pox;
  logic [2*SizeW-1:0] poy;
  logic [2*SizeW-1:0] psx;
  logic [2*SizeW-1:0] psy;
  logic    out_valid_r;
  result_t res_r;
  result_t res_nxt;
  item_t   fin;

  // whole back pipeline moves together when the output slot frees
  assign adv     = !out_valid_r || out_ch.ready;
  assign b_ready = adv;

  assign pox = b_item.ox * b_item.tw;
  assign poy = b_item.oy * b_item.th;
  assign psx = b_item.sx * b_item.tw;
  assign psy = b_item.sy * b_item.th;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= b_valid;
    end
    if (adv) begin
      it_r[0]  <= b_item;
      dox_r[0] <= pox;
      doy_r[0] <= poy;
      dsx_r[0] <= psx;
      dsy_r[0] <= psy;
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (adv) begin
        v_r[k+1] <= v_r[k];
      end
      if (adv) begin
        it_r[k+1]  <= it_r[k];
        dox_r[k+1] <= div_step(dox_r[k], it_r[k].qw);
        doy_r[k+1] <= div_step(doy_r[k], it_r[k].qh);
        dsx_r[k+1] <= div_step(dsx_r[k], it_r[k].qw);
        dsy_r[k+1] <= div_step(dsy_r[k], it_r[k].qh);
      end
    end
  end

  assign fin = it_r[Steps];

  always_comb begin
    res_nxt = '0;
    case (fin.status)
      ST_PASS: begin
        res_nxt.status = ST_PASS;
        res_nxt.x      = fin.qx;
        res_nxt.y      = fin.qy;
        res_nxt.w      = fin.qw;
        res_nxt.h      = fin.qh;
        res_nxt.tex_x  = fin.tx;
        res_nxt.tex_y  = fin.ty;
        res_nxt.tex_w  = fin.tw;
        res_nxt.tex_h  = fin.th;
      end
      ST_CLIP: begin
        res_nxt.status = ST_CLIP;
        res_nxt.x      = fin.lx;
        res_nxt.y      = fin.ly;
        res_nxt.w      = fin.sx;
        res_nxt.h      = fin.sy;
        res_nxt.tex_x  = add_sat(fin.tx, dox_r[Steps].quo);
        res_nxt.tex_y  = add_sat(fin.ty, doy_r[Steps].quo);
        res_nxt.tex_w  = dsx_r[Steps].quo;
        res_nxt.tex_h  = dsy_r[Steps].quo;
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[Steps];
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.clip_status = res_r.status;
  assign out_ch.out_x       = res_r.x;
  assign out_ch.out_y       = res_r.y;
  assign out_ch.out_w       = res_r.w;
  assign out_ch.out_h       = res_r.h;
  assign out_ch.out_tex_x   = res_r.tex_x;
  assign out_ch.out_tex_y   = res_r.tex_y;
  assign out_ch.out_tex_w   = res_r.tex_w;
  assign out_ch.out_tex_h   = res_r.tex_h;
endmodule

[src/textured_quad_clipper_unit.sv]
// ----------------------------------------------------------------------------
// textured_quad_clipper_unit
// Clips axis-aligned quads against a clip box and rescales their texture rect.
// ----------------------------------------------------------------------------
// Takes one quad per clock and returns one result per clock in order while
// out_ch.ready does not stall the output register. Accepted quads pass one
// classify stage, the queue, one product stage, 19 restoring divider stages
// (one quotient bit each, set by the 19-bit quad size) and the output
// register. Write the clip box registers through cfg_* while idle; the block itself does not enforce it.
module textured_quad_clipper_unit #(
  parameter int QueueDepth = tqc_pkg::QueueDepth
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [tqc_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [tqc_pkg::CfgDataW-1:0] cfg_data,
  tqc_in_if.sink                       in_ch,
  tqc_out_if.source                    out_ch
);
  import tqc_pkg::*;

  cfg_t  cfg_r;
  logic  f_valid;
  logic  f_ready;
  item_t f_item;
  logic  b_valid;
  logic  b_ready;
  item_t b_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_CLIP_LEFT:   cfg_r.left   <= cfg_data[PosW-1:0];
        CFG_CLIP_TOP:    cfg_r.top    <= cfg_data[PosW-1:0];
        CFG_CLIP_WIDTH:  cfg_r.width  <= cfg_data[SizeW-1:0];
        CFG_CLIP_HEIGHT: cfg_r.height <= cfg_data[SizeW-1:0];
        default: begin
        end
      endcase
    end
  end

  tqc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_ch   (in_ch),
    .f_valid (f_valid),
    .f_item  (f_item),
    .f_ready (f_ready)
  );

  tqc_queue #(.Depth(QueueDepth)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_item   (b_item)
  );

  tqc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .b_valid (b_valid),
    .b_ready (b_ready),
    .b_item  (b_item),
    .out_ch  (out_ch)
  );
endmodule
